### src/twrb_pkg.sv
// ----------------------------------------------------------------------------
// twrb_pkg
// Shared types and constants for the timestamp window reorder buffer.
// ----------------------------------------------------------------------------
package twrb_pkg;

    localparam int DEPTH = 64;
    localparam int TS_W  = 48;
    localparam int TAG_W = 16;
    // pointer / count width: holds DEPTH + 1 entries (one staging slot)
    localparam int AW    = $clog2(DEPTH + 2);
    localparam int MEM_N = 2 ** AW;

    localparam logic [TS_W-1:0] WINDOW_RESET = 48'd1000000;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [TS_W-1:0]  timestamp;
        logic [TAG_W-1:0] message_id;
    } t_in_req;

    typedef struct packed {
        logic [TS_W-1:0]  out_timestamp;
        logic [TAG_W-1:0] out_message_id;
        logic             last;
        logic             forced;
    } t_out_rsp;

    typedef struct packed {
        logic [TS_W-1:0]  ts;
        logic [TAG_W-1:0] tag;
    } t_entry;

    function automatic t_out_rsp make_rsp(t_entry e, logic forced);
        t_out_rsp r;
        r.out_timestamp  = e.ts;
        r.out_message_id = e.tag;
        r.last           = 1'b0;
        r.forced         = forced;
        return r;
    endfunction

endpackage

### src/timestamp_window_reorder_buffer.sv
// ----------------------------------------------------------------------------
// timestamp_window_reorder_buffer
// Sorts timestamped message tags and releases them in time order.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready, i_in_data): insert or flush request.
// Output channel (o_out_valid / i_out_ready, o_out_data): released messages,
// oldest first; last marks the final release of a request, forced marks an
// early release because the store was full.
// Config: i_cfg_we / i_cfg_wdata load the window; write only while idle.
// Entries sit sorted in a circular buffer in one memory with a registered read.
// An insert walks from the tail, moving each later entry up one slot, then
// checks the head and releases the entries that have aged out of the window;
// when none has aged and the store is over full, it forces out the head.
// A flush releases every entry in order.
// A release is held in a pending register until the next release or the end
// of the request shows whether it is last.
// A dropped insert is done in the accept cycle.
// Reset empties the store, clears both kept times, sets the window to 1 s.
// While the receiver stalls the output register holds and the sequencer
// waits before reading the next head entry.
// ----------------------------------------------------------------------------
module timestamp_window_reorder_buffer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  twrb_pkg::t_in_req             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output twrb_pkg::t_out_rsp            o_out_data,
    input  logic                          i_cfg_we,
    input  logic [twrb_pkg::TS_W-1:0]     i_cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_INS_RD, S_INS_CHK, S_REL_RD, S_REL_CHK,
        S_FRC_RD, S_FRC_CHK, S_FL_RD, S_FL_CHK, S_FIN
    } t_state;

    localparam logic [twrb_pkg::AW-1:0] DEPTH_A = twrb_pkg::AW'(twrb_pkg::DEPTH);

    t_state                      r_state;
    logic [twrb_pkg::TS_W-1:0]   r_window;
    logic [twrb_pkg::AW-1:0]     r_count;
    logic [twrb_pkg::AW-1:0]     r_head;
    logic [twrb_pkg::AW-1:0]     r_pos;
    logic [twrb_pkg::AW-1:0]     r_k;
    logic [twrb_pkg::TS_W-1:0]   r_oldest;
    logic [twrb_pkg::TS_W-1:0]   r_newest;
    twrb_pkg::t_in_req           r_req;
    logic                        r_pend_valid;
    twrb_pkg::t_out_rsp          r_pend;
    logic                        r_out_valid;
    twrb_pkg::t_out_rsp          r_out;

    logic                        mem_we;
    logic [twrb_pkg::AW-1:0]     mem_waddr;
    twrb_pkg::t_entry            mem_wdata;
    logic [twrb_pkg::AW-1:0]     mem_raddr;
    twrb_pkg::t_entry            rd;
    twrb_pkg::t_entry            new_entry;
    logic                        out_free;
    logic                        can_emit;
    logic                        aged;
    logic                        rel_take;
    logic                        out_load;
    twrb_pkg::t_out_rsp          pend_done;

    twrb_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd)
    );

    assign new_entry = '{ts: r_req.timestamp, tag: r_req.message_id};
    assign out_free  = !r_out_valid || i_out_ready;
    assign can_emit  = !r_pend_valid || out_free;
    assign aged      = ({1'b0, rd.ts} + {1'b0, r_window}) < {1'b0, r_newest};
    assign rel_take  = (r_k != DEPTH_A) && aged;
    assign out_load  = r_pend_valid &&
                       (((r_state == S_REL_CHK) && rel_take) ||
                        (r_state == S_FL_CHK) ||
                        ((r_state == S_FIN) && out_free));

    always_comb begin
        pend_done      = r_pend;
        pend_done.last = 1'b1;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_head + r_pos;
        mem_wdata = new_entry;
        mem_raddr = r_head;
        unique case (r_state)
            S_INS_RD: begin
                if (r_pos == '0) begin
                    mem_we = 1'b1;
                end else begin
                    mem_raddr = r_head + r_pos - 1'b1;
                end
            end
            S_INS_CHK: begin
                mem_we = 1'b1;
                if (rd.ts > r_req.timestamp) begin
                    mem_wdata = rd;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_window     <= twrb_pkg::WINDOW_RESET;
            r_count      <= '0;
            r_head       <= '0;
            r_pos        <= '0;
            r_k          <= '0;
            r_oldest     <= '0;
            r_newest     <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req <= i_in_data;
                        r_k   <= '0;
                        r_pos <= r_count;
                        if (i_in_data.req_type == twrb_pkg::REQ_FLUSH) begin
                            r_state <= S_FL_RD;
                        end else if (i_in_data.timestamp >= r_oldest) begin
                            if (i_in_data.timestamp > r_newest) begin
                                r_newest <= i_in_data.timestamp;
                            end
                            r_state <= S_INS_RD;
                        end
                    end
                end
                S_INS_RD: begin
                    if (r_pos == '0) begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_REL_RD;
                    end else begin
                        r_state <= S_INS_CHK;
                    end
                end
                S_INS_CHK: begin
                    if (rd.ts > r_req.timestamp) begin
                        r_pos   <= r_pos - 1'b1;
                        r_state <= S_INS_RD;
                    end else begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_REL_RD;
                    end
                end
                S_REL_RD: begin
                    if (r_count == '0) begin
                        r_state <= S_FIN;
                    end else if (can_emit) begin
                        r_state <= S_REL_CHK;
                    end
                end
                S_REL_CHK: begin
                    if (rel_take) begin
                        if (r_pend_valid) begin
                            r_out <= r_pend;
                        end
                        r_pend       <= twrb_pkg::make_rsp(rd, 1'b0);
                        r_pend_valid <= 1'b1;
                        r_oldest     <= rd.ts;
                        r_head       <= r_head + 1'b1;
                        r_count      <= r_count - 1'b1;
                        r_k          <= r_k + 1'b1;
                        r_state      <= S_REL_RD;
                    end else if (r_k != '0) begin
                        r_oldest <= rd.ts;
                        r_state  <= S_FIN;
                    end else if (r_count > DEPTH_A) begin
                        // store overflow: push out the head early
                        r_pend       <= twrb_pkg::make_rsp(rd, 1'b1);
                        r_pend_valid <= 1'b1;
                        r_head       <= r_head + 1'b1;
                        r_count      <= r_count - 1'b1;
                        r_state      <= S_FRC_RD;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FRC_RD: begin
                    r_state <= S_FRC_CHK;
                end
                S_FRC_CHK: begin
                    r_oldest <= rd.ts;
                    r_state  <= S_FIN;
                end
                S_FL_RD: begin
                    if (r_count == '0) begin
                        r_state <= S_FIN;
                    end else if (can_emit) begin
                        r_state <= S_FL_CHK;
                    end
                end
                S_FL_CHK: begin
                    if (r_pend_valid) begin
                        r_out <= r_pend;
                    end
                    r_pend       <= twrb_pkg::make_rsp(rd, 1'b0);
                    r_pend_valid <= 1'b1;
                    r_head       <= r_head + 1'b1;
                    r_count      <= r_count - 1'b1;
                    r_state      <= S_FL_RD;
                end
                S_FIN: begin
                    if (!r_pend_valid) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out        <= pend_done;
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### src/twrb_store.sv
// ----------------------------------------------------------------------------
// twrb_store
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module twrb_store (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [twrb_pkg::AW-1:0]  i_waddr,
    input  twrb_pkg::t_entry         i_wdata,
    input  logic [twrb_pkg::AW-1:0]  i_raddr,
    output twrb_pkg::t_entry         o_rdata
);

    twrb_pkg::t_entry mem [twrb_pkg::MEM_N];
    twrb_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/twrb_checker.sv
// ----------------------------------------------------------------------------
// twrb_checker
// Port-level checks for the timestamp window reorder buffer.
// ----------------------------------------------------------------------------
module twrb_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_ready,
    input  twrb_pkg::t_in_req             i_in_data,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  twrb_pkg::t_out_rsp            o_out_data,
    input  logic                          i_cfg_we
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled release changed");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("not idle after reset");

    a_flush_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.req_type == twrb_pkg::REQ_FLUSH
        |=> !o_in_ready)
        else $error("flush request did not occupy the block");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> o_in_ready)
        else $error("window written while busy");

endmodule

bind timestamp_window_reorder_buffer twrb_checker u_twrb_checker (.*);

### dv/timestamp_window_reorder_buffer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timestamp_window_reorder_buffer_tb
// Directed and random check of the timestamp window reorder buffer.
// ----------------------------------------------------------------------------
// A request driver and a release sink work the two valid/ready channels with
// random gaps. A release-order predictor keeps its own sorted store and
// queues the releases each accepted request causes; every accepted release
// is compared field by field. The window is rewritten between phases while
// the block is idle. One long sink stall stalls requests.
// ----------------------------------------------------------------------------
module timestamp_window_reorder_buffer_tb;

    localparam int  HALF_PERIOD = 6;
    localparam int  SETTLE      = 400;
    localparam int  STALL_LIMIT = 4000;
    localparam int  LONG_HOLD   = 600;
    localparam logic [twrb_pkg::TS_W-1:0] TS_MAX = '1;

    class release_order_board;
        logic [twrb_pkg::TS_W-1:0]  etime [twrb_pkg::DEPTH+1];
        logic [twrb_pkg::TAG_W-1:0] etag  [twrb_pkg::DEPTH+1];
        int                         count;
        logic [twrb_pkg::TS_W-1:0]  oldest;
        logic [twrb_pkg::TS_W-1:0]  newest;
        logic [twrb_pkg::TS_W-1:0]  window;
        twrb_pkg::t_out_rsp         exp_q [$];
        int                         errors;
        int                         n_req;
        int                         n_rel;
        int                         n_forced;
        int                         n_dropped;

        function new();
            count  = 0;
            oldest = '0;
            newest = '0;
            window = twrb_pkg::WINDOW_RESET;
            errors = 0;
            n_req = 0; n_rel = 0; n_forced = 0; n_dropped = 0;
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        function void drop_head(int k);
            for (int i = 0; i + k < count; i++) begin
                etime[i] = etime[i+k];
                etag[i]  = etag[i+k];
            end
            count -= k;
        endfunction

        function twrb_pkg::t_out_rsp mk(int i, logic frc);
            twrb_pkg::t_out_rsp r;
            r.out_timestamp  = etime[i];
            r.out_message_id = etag[i];
            r.last           = 1'b0;
            r.forced         = frc;
            return r;
        endfunction

        function void note_request(twrb_pkg::t_in_req r);
            twrb_pkg::t_out_rsp rel [$];
            int                 pos;
            int                 k;
            n_req++;
            if (r.req_type == twrb_pkg::REQ_FLUSH) begin
                for (int i = 0; i < count; i++) rel.push_back(mk(i, 1'b0));
                count = 0;
            end else if (r.timestamp < oldest) begin
                n_dropped++;
            end else begin
                pos = count;
                while (pos > 0 && etime[pos-1] > r.timestamp) begin
                    etime[pos] = etime[pos-1];
                    etag[pos]  = etag[pos-1];
                    pos--;
                end
                etime[pos] = r.timestamp;
                etag[pos]  = r.message_id;
                count++;
                if (r.timestamp > newest) newest = r.timestamp;
                k = 0;
                while (k < count && k < twrb_pkg::DEPTH &&
                       ({1'b0, etime[k]} + {1'b0, window}) < {1'b0, newest}) begin
                    rel.push_back(mk(k, 1'b0));
                    oldest = etime[k];
                    k++;
                end
                if (k > 0) begin
                    drop_head(k);
                    if (count > 0) oldest = etime[0];
                end else if (count > twrb_pkg::DEPTH) begin
                    rel.push_back(mk(0, 1'b1));
                    n_forced++;
                    drop_head(1);
                    oldest = etime[0];
                end
            end
            if (rel.size() > 0) rel[rel.size()-1].last = 1'b1;
            foreach (rel[i]) exp_q.push_back(rel[i]);
        endfunction

        task check_release(twrb_pkg::t_out_rsp got);
            twrb_pkg::t_out_rsp e;
            n_rel++;
            if (exp_q.size() == 0) begin
                report_mismatch($sformatf("unexpected release ts=%0h id=%0h",
                                          got.out_timestamp, got.out_message_id));
                return;
            end
            e = exp_q.pop_front();
            if (got.out_timestamp !== e.out_timestamp)
                report_mismatch($sformatf("out_timestamp %0h, expected %0h",
                                          got.out_timestamp, e.out_timestamp));
            if (got.out_message_id !== e.out_message_id)
                report_mismatch($sformatf("out_message_id %0h, expected %0h",
                                          got.out_message_id, e.out_message_id));
            if (got.last !== e.last)
                report_mismatch($sformatf("last %b, expected %b ts=%0h",
                                          got.last, e.last, e.out_timestamp));
            if (got.forced !== e.forced)
                report_mismatch($sformatf("forced %b, expected %b ts=%0h",
                                          got.forced, e.forced, e.out_timestamp));
        endtask
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        in_valid;
    logic                        o_in_ready;
    twrb_pkg::t_in_req           in_data;
    logic                        o_out_valid;
    logic                        out_ready;
    twrb_pkg::t_out_rsp          o_out_data;
    logic                        cfg_we;
    logic [twrb_pkg::TS_W-1:0]   cfg_wdata;

    release_order_board board;
    logic              send_idle_en;
    logic              sink_idle_en;
    logic              hold_req;
    int                stall_cnt;

    timestamp_window_reorder_buffer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // release sink
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 19) == 0) sink_idle_en = ~sink_idle_en;
            gap = sink_idle_en ? $urandom_range(0, 14) : 0;
            if (hold_req) begin
                hold_req = 1'b0;
                gap = LONG_HOLD;
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            board.check_release(o_out_data);
            @(negedge i_clk);
        end
    end

    task send_req(logic rt, logic [twrb_pkg::TS_W-1:0] ts,
                  logic [twrb_pkg::TAG_W-1:0] id);
        int                gap;
        twrb_pkg::t_in_req r;
        r.req_type   = rt;
        r.timestamp  = ts;
        r.message_id = id;
        if ($urandom_range(0, 19) == 0) send_idle_en = ~send_idle_en;
        gap = send_idle_en ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_request(r);
        @(negedge i_clk);
    endtask

    task wait_idle();
        in_valid <= 1'b0;
        while (board.exp_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task set_window(logic [twrb_pkg::TS_W-1:0] w);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        board.window = w;
    endtask

    task random_phase(int n_items, logic [twrb_pkg::TS_W-1:0] base_in, int step, int span);
        logic [twrb_pkg::TS_W-1:0] base;
        logic [twrb_pkg::TS_W-1:0] ts;
        int                        pick;
        base = base_in;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            base = base + twrb_pkg::TS_W'($urandom_range(0, step));
            if (pick < 5) begin
                send_req(twrb_pkg::REQ_FLUSH, twrb_pkg::TS_W'({$urandom, $urandom}),
                         twrb_pkg::TAG_W'($urandom));
            end else if (pick < 13 && board.oldest > 0) begin
                ts = board.oldest - twrb_pkg::TS_W'($urandom_range(1, 50));
                if (ts > board.oldest) ts = '0;
                send_req(twrb_pkg::REQ_INSERT, ts, twrb_pkg::TAG_W'($urandom));
            end else begin
                ts = base + twrb_pkg::TS_W'($urandom_range(0, span));
                send_req(twrb_pkg::REQ_INSERT, ts, twrb_pkg::TAG_W'($urandom));
            end
        end
    endtask

    initial begin
        logic [twrb_pkg::TS_W-1:0] hb;
        board        = new();
        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_ready    = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        send_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        hold_req     = 1'b0;
        stall_cnt    = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: reset window, equal times, drop, flush
        send_req(twrb_pkg::REQ_INSERT, 48'd0, 16'h0000);
        send_req(twrb_pkg::REQ_INSERT, 48'd5, 16'h1111);
        send_req(twrb_pkg::REQ_INSERT, 48'd5, 16'h2222);
        send_req(twrb_pkg::REQ_INSERT, 48'd5, 16'hFFFF);
        send_req(twrb_pkg::REQ_INSERT, 48'd2000000, 16'h3333);
        send_req(twrb_pkg::REQ_INSERT, 48'd1, 16'h4444);
        send_req(twrb_pkg::REQ_FLUSH, 48'd0, 16'h0);
        send_req(twrb_pkg::REQ_FLUSH, TS_MAX, 16'hFFFF);
        // zero window, a release by an insert, then drops after a flush
        set_window('0);
        send_req(twrb_pkg::REQ_INSERT, 48'd3000000, 16'h5555);
        send_req(twrb_pkg::REQ_INSERT, 48'd3000001, 16'h6666);
        send_req(twrb_pkg::REQ_FLUSH, 48'd0, 16'h0);
        send_req(twrb_pkg::REQ_INSERT, 48'd3000000, 16'h7777);
        send_req(twrb_pkg::REQ_INSERT, 48'd2999999, 16'h8888);
        // full store, forced release, then a full-budget release
        set_window(TS_MAX);
        for (int i = 0; i < twrb_pkg::DEPTH + 3; i++)
            send_req(twrb_pkg::REQ_INSERT,
                     48'd3000100 + twrb_pkg::TS_W'($urandom_range(0, 40)),
                     twrb_pkg::TAG_W'($urandom));
        set_window('0);
        send_req(twrb_pkg::REQ_INSERT, 48'd4000000, 16'hABCD);
        send_req(twrb_pkg::REQ_FLUSH, 48'd0, 16'h0);

        set_window(48'd150);
        hold_req = 1'b1;
        random_phase(80, 48'd5000000, 20, 400);
        set_window(48'd40000);
        random_phase(60, 48'd6000000, 3000, 60000);
        set_window(TS_MAX);
        random_phase(60, 48'd7000000, 5, 100);
        set_window(48'd7);
        random_phase(50, 48'd8000000, 3, 20);
        hb = {1'b1, 15'($urandom), 32'($urandom)};
        set_window(48'd1000);
        random_phase(50, hb, 200, 3000);
        send_req(twrb_pkg::REQ_INSERT, TS_MAX, 16'hFFFF);
        send_req(twrb_pkg::REQ_FLUSH, 48'd0, 16'h0);
        wait_idle();

        if (board.exp_q.size() != 0)
            board.report_mismatch($sformatf("%0d releases never arrived",
                                            board.exp_q.size()));
        $display("covered %0d requests (%0d dropped), %0d releases, %0d forced",
                 board.n_req, board.n_dropped, board.n_rel, board.n_forced);
        $display("windows: reset, 0, 7, 150, 1000, 40000 and all ones");
        if (board.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
